### design/svgp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgp_pkg
// Shared constants of the spatial voice gain and pan block.
// ----------------------------------------------------------------------------
package svgp_pkg;

	// volume cap, 4.0 in Q4.12
	localparam logic [15:0] VOLUME_CAP = 16'd16384;

	// listener gain after reset, 1.0 in Q4.12
	localparam logic [15:0] LISTENER_GAIN_RESET = 16'd4096;

	// largest channel gain
	localparam logic [23:0] GAIN_MAX = 24'hFFFFFF;

endpackage
`default_nettype wire

### design/svgp_isqrt_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgp_isqrt_pipe
// Pipelined integer square root, one result bit per stage, several lanes
// in lockstep with a side payload carried alongside.
// ----------------------------------------------------------------------------
module svgp_isqrt_pipe #(
	parameter int IN_W   = 64,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire logic                           in_valid,
	input  wire logic [LANES-1:0][IN_W-1:0]     rad,
	input  wire logic [SIDE_W-1:0]              side_in,
	output logic                                out_valid,
	output logic [LANES-1:0][IN_W/2-1:0]        root,
	output logic [SIDE_W-1:0]                   side_out
);

	localparam int STEPS = IN_W / 2;

	logic                       vld_s  [1:STEPS];
	logic [LANES-1:0][IN_W-1:0] rem_s  [1:STEPS];
	logic [LANES-1:0][IN_W-1:0] res_s  [1:STEPS];
	logic [SIDE_W-1:0]          side_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam logic [IN_W-1:0] BIT = {{(IN_W-1){1'b0}}, 1'b1} << (IN_W - 2 - 2 * k);

		logic                       cur_v;
		logic [LANES-1:0][IN_W-1:0] cur_rem;
		logic [LANES-1:0][IN_W-1:0] cur_res;
		logic [SIDE_W-1:0]          cur_side;
		logic [LANES-1:0][IN_W-1:0] nrem;
		logic [LANES-1:0][IN_W-1:0] nres;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_rem  = rad;
			assign cur_res  = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = vld_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_res  = res_s[k];
			assign cur_side = side_s[k];
		end

		// one restoring step per lane
		always_comb begin
			for (int l = 0; l < LANES; l++) begin
				if (cur_rem[l] >= cur_res[l] + BIT) begin
					nrem[l] = cur_rem[l] - (cur_res[l] + BIT);
					nres[l] = (cur_res[l] >> 1) + BIT;
				end else begin
					nrem[l] = cur_rem[l];
					nres[l] = cur_res[l] >> 1;
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= nrem;
				res_s[k+1]  <= nres;
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign side_out  = side_s[STEPS];

	always_comb begin
		for (int l = 0; l < LANES; l++) begin
			root[l] = res_s[STEPS][l][STEPS-1:0];
		end
	end

endmodule
`default_nettype wire

### design/svgp_frac_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// svgp_frac_div_pipe
// Pipelined fractional divider: floor(num * 2^QB / den) for num <= den,
// one quotient bit per stage, several lanes with a side payload.
// ----------------------------------------------------------------------------
module svgp_frac_div_pipe #(
	parameter int W      = 34,
	parameter int QB     = 16,
	parameter int LANES  = 1,
	parameter int SIDE_W = 1
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        en,
	input  wire logic                        in_valid,
	input  wire logic [LANES-1:0][W-1:0]     num,
	input  wire logic [LANES-1:0][W-1:0]     den,
	input  wire logic [SIDE_W-1:0]           side_in,
	output logic                             out_valid,
	output logic [LANES-1:0][QB:0]           quot,
	output logic [SIDE_W-1:0]                side_out
);

	localparam int STEPS = QB + 1;

	logic                     vld_s  [1:STEPS];
	logic [LANES-1:0][W-1:0]  rem_s  [1:STEPS];
	logic [LANES-1:0][W-1:0]  den_s  [1:STEPS];
	logic [LANES-1:0][QB:0]   q_s    [1:STEPS];
	logic [SIDE_W-1:0]        side_s [1:STEPS];

	for (genvar k = 0; k < STEPS; k++) begin : g_step
		localparam bit FIRST = (k == 0);

		logic                    cur_v;
		logic [LANES-1:0][W-1:0] cur_rem;
		logic [LANES-1:0][W-1:0] cur_den;
		logic [LANES-1:0][QB:0]  cur_q;
		logic [SIDE_W-1:0]       cur_side;
		logic [LANES-1:0][W-1:0] nrem;
		logic [LANES-1:0][QB:0]  nq;

		if (k == 0) begin : g_first
			assign cur_v    = in_valid;
			assign cur_rem  = num;
			assign cur_den  = den;
			assign cur_q    = '0;
			assign cur_side = side_in;
		end else begin : g_next
			assign cur_v    = vld_s[k];
			assign cur_rem  = rem_s[k];
			assign cur_den  = den_s[k];
			assign cur_q    = q_s[k];
			assign cur_side = side_s[k];
		end

		// integer part first, then one fraction bit per step
		always_comb begin
			logic [W:0] t;
			logic [W:0] diff;
			logic       ge;
			for (int l = 0; l < LANES; l++) begin
				t     = FIRST ? {1'b0, cur_rem[l]} : {cur_rem[l], 1'b0};
				diff  = t - {1'b0, cur_den[l]};
				ge    = (t >= {1'b0, cur_den[l]});
				nrem[l] = ge ? diff[W-1:0] : t[W-1:0];
				nq[l]   = {cur_q[l][QB-1:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k+1] <= 1'b0;
			end else if (en) begin
				vld_s[k+1] <= cur_v;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= nrem;
				den_s[k+1]  <= cur_den;
				q_s[k+1]    <= nq;
				side_s[k+1] <= cur_side;
			end
		end
	end

	assign out_valid = vld_s[STEPS];
	assign quot      = q_s[STEPS];
	assign side_out  = side_s[STEPS];

endmodule
`default_nettype wire

### design/spatial_voice_gain_pan.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spatial_voice_gain_pan
// Per-voice gain: clamped volume times listener gain, inverse distance
// attenuation with linear fade, equal-power pan, silence detect.
// ----------------------------------------------------------------------------
// usage
//   input channel: in_valid / in_stall with one voice per request (offset,
//     volume, min and max distance, spatial flag)
//   output channel: out_valid / out_stall with left_gain, right_gain, silent
//   config channel: cfg_valid / cfg_ready / cfg_data writes listener_gain;
//     cfg_ready is always high, write only while the pipeline is empty
//   throughput: one voice per cycle while no output request is held, no bubbles between requests
//   pipeline: registered stages 1 to 9 with the bit-per-stage units between
//     them: distance and radius roots (32),
//     attenuation divide (G+1), pan divide (2G+1), pan roots (G+1)
//   out_stall freezes the whole pipeline while the output register holds a
//     request; in_stall follows it then, nothing is dropped or repeated
//   reset: all valid bits clear, listener_gain returns to 1.0
// ----------------------------------------------------------------------------
module spatial_voice_gain_pan #(
	parameter int POS_FRAC_BITS  = 8,
	parameter int GAIN_FRAC_BITS = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic signed [23:0] offset_x,
	input  wire logic signed [23:0] offset_y,
	input  wire logic signed [23:0] offset_z,
	input  wire logic [15:0]        volume,
	input  wire logic [23:0]        min_distance,
	input  wire logic [23:0]        max_distance,
	input  wire logic               spatial,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [23:0]             left_gain,
	output logic [23:0]             right_gain,
	output logic                    silent,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [15:0]        cfg_data
);

	localparam int G       = GAIN_FRAC_BITS;
	localparam int VL_W    = 30;             // clamped volume times listener gain
	localparam int T_W     = VL_W + G;       // total gain, 24+G fraction bits
	localparam int GV_W    = T_W - 24;       // gain, G fraction bits
	localparam int FQ_W    = G + 1;          // pan factor
	localparam int PROD_W  = GV_W + FQ_W;
	localparam int SH_W    = PROD_W - G;
	localparam int SAT_W   = (SH_W > 25) ? SH_W : 25;
	localparam int DA_W    = 50;             // attenuation divide operands
	localparam int DP_W    = 34;             // pan divide operands
	localparam int SIDE1_W = VL_W + 24 + 25 + 1 + 1 + 24 + 1;
	localparam int SIDEA_W = VL_W + 3 + 3 * DP_W;
	localparam int SIDEP_W = GV_W + 2;

	localparam logic [23:0] MIN_FLOOR = 24'(((5 << POS_FRAC_BITS) + 50) / 100);
	localparam logic [G:0]  GAIN_ONE  = {1'b1, {G{1'b0}}};
	localparam longint unsigned SILENT_LIMIT = (64'd1 << (24 + G)) / 64'd100000;

	// global pipeline advance: only a held output request blocks it
	logic en;
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// listener gain register
	logic [15:0] lg_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lg_q <= svgp_pkg::LISTENER_GAIN_RESET;
		end else if (cfg_valid && cfg_ready) begin
			lg_q <= cfg_data;
		end
	end

	// ---------------- stage 1: magnitudes and clamps ----------------
	logic [23:0] ax_c, ay_c, az_c, mn_c;
	logic [24:0] mx_lim_c, mx_c;
	logic [14:0] vol_c;

	always_comb begin
		ax_c     = offset_x[23] ? (~offset_x + 24'd1) : offset_x;
		ay_c     = offset_y[23] ? (~offset_y + 24'd1) : offset_y;
		az_c     = offset_z[23] ? (~offset_z + 24'd1) : offset_z;
		vol_c    = (volume > svgp_pkg::VOLUME_CAP) ? svgp_pkg::VOLUME_CAP[14:0] : volume[14:0];
		mn_c     = (min_distance < MIN_FLOOR) ? MIN_FLOOR : min_distance;
		mx_lim_c = {1'b0, mn_c} + {1'b0, MIN_FLOOR};
		mx_c     = ({1'b0, max_distance} < mx_lim_c) ? mx_lim_c : {1'b0, max_distance};
	end

	logic        vld_s1;
	logic [23:0] ax_s1, ay_s1, az_s1, mn_s1;
	logic [24:0] mx_s1;
	logic [14:0] vol_s1;
	logic        xneg_s1, sp_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1   <= ax_c;
			ay_s1   <= ay_c;
			az_s1   <= az_c;
			xneg_s1 <= offset_x[23];
			vol_s1  <= vol_c;
			mn_s1   <= mn_c;
			mx_s1   <= mx_c;
			sp_s1   <= spatial;
		end
	end

	// ---------------- stage 2: squares and base gain ----------------
	logic        vld_s2;
	logic [47:0] sqx_s2, sqy_s2, sqz_s2;
	logic [VL_W-1:0] vl_s2;
	logic [23:0] ax_s2, mn_s2;
	logic [24:0] mx_s2;
	logic        xneg_s2, sp_s2, r2z_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (en) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s2  <= 48'(ax_s1) * 48'(ax_s1);
			sqy_s2  <= 48'(ay_s1) * 48'(ay_s1);
			sqz_s2  <= 48'(az_s1) * 48'(az_s1);
			vl_s2   <= VL_W'(vol_s1) * VL_W'(lg_q);
			ax_s2   <= ax_s1;
			mn_s2   <= mn_s1;
			mx_s2   <= mx_s1;
			xneg_s2 <= xneg_s1;
			sp_s2   <= sp_s1;
			r2z_s2  <= (ax_s1 == 24'd0) && (az_s1 == 24'd0);
		end
	end

	// ---------------- stage 3: squared distance and radius ----------------
	logic        vld_s3;
	logic [47:0] sum_s3, r2_s3;
	logic [VL_W-1:0] vl_s3;
	logic [23:0] ax_s3, mn_s3;
	logic [24:0] mx_s3;
	logic        xneg_s3, sp_s3, r2z_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s3  <= sqx_s2 + sqy_s2 + sqz_s2;
			r2_s3   <= sqx_s2 + sqz_s2;
			vl_s3   <= vl_s2;
			ax_s3   <= ax_s2;
			mn_s3   <= mn_s2;
			mx_s3   <= mx_s2;
			xneg_s3 <= xneg_s2;
			sp_s3   <= sp_s2;
			r2z_s3  <= r2z_s2;
		end
	end

	// ---------------- distance and pan radius roots ----------------
	// lane 0: distance, lane 1: radius of x and z scaled by 2^8
	logic                  vld_r1;
	logic [1:0][31:0]      root_r1;
	logic [SIDE1_W-1:0]    side_r1;

	svgp_isqrt_pipe #(
		.IN_W   (64),
		.LANES  (2),
		.SIDE_W (SIDE1_W)
	) u_root_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s3),
		.rad      ({{r2_s3, 16'd0}, {16'd0, sum_s3}}),
		.side_in  ({vl_s3, mn_s3, mx_s3, sp_s3, xneg_s3, ax_s3, r2z_s3}),
		.out_valid(vld_r1),
		.root     (root_r1),
		.side_out (side_r1)
	);

	// ---------------- stage 4: distance compares, pan numerators ----------------
	logic [VL_W-1:0] vl_r;
	logic [23:0] mn_r, ax_r;
	logic [24:0] mx_r, d_c;
	logic        sp_r, xneg_r, r2z_r;
	logic [31:0] r_c, xsf_c, xs_c;
	logic [DP_W-1:0] psum_c, pdif_c, nl_c, nr_c, dp_c;

	always_comb begin
		{vl_r, mn_r, mx_r, sp_r, xneg_r, ax_r, r2z_r} = side_r1;
		d_c    = root_r1[0][24:0];
		r_c    = root_r1[1];
		xsf_c  = {ax_r, 8'd0};
		xs_c   = (xsf_c > r_c) ? r_c : xsf_c;
		psum_c = {2'b00, r_c} + {2'b00, xs_c};
		pdif_c = {2'b00, r_c} - {2'b00, xs_c};
		// source at the listener or on the y axis: centered
		if (r2z_r) begin
			nl_c = DP_W'(1);
			nr_c = DP_W'(1);
			dp_c = DP_W'(2);
		end else begin
			nl_c = xneg_r ? psum_c : pdif_c;
			nr_c = xneg_r ? pdif_c : psum_c;
			dp_c = {1'b0, r_c, 1'b0};
		end
	end

	logic        vld_s4;
	logic [24:0] d_s4, df1_s4, df2_s4;
	logic [23:0] mn_s4;
	logic        lemin_s4, gemax_s4, sp_s4;
	logic [VL_W-1:0] vl_s4;
	logic [DP_W-1:0] nl_s4, nr_s4, dp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_r1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_s4     <= d_c;
			lemin_s4 <= (d_c <= {1'b0, mn_r});
			gemax_s4 <= (d_c >= mx_r);
			df1_s4   <= mx_r - d_c;
			df2_s4   <= mx_r - {1'b0, mn_r};
			mn_s4    <= mn_r;
			vl_s4    <= vl_r;
			sp_s4    <= sp_r;
			nl_s4    <= nl_c;
			nr_s4    <= nr_c;
			dp_s4    <= dp_c;
		end
	end

	// ---------------- stage 5: attenuation numerator and denominator ----------------
	logic            vld_s5;
	logic [DA_W-1:0] na_s5, da_s5;
	logic            lemin_s5, gemax_s5, sp_s5;
	logic [VL_W-1:0] vl_s5;
	logic [DP_W-1:0] nl_s5, nr_s5, dp_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			na_s5    <= DA_W'(mn_s4) * DA_W'(df1_s4);
			da_s5    <= DA_W'(d_s4) * DA_W'(df2_s4);
			lemin_s5 <= lemin_s4;
			gemax_s5 <= gemax_s4;
			sp_s5    <= sp_s4;
			vl_s5    <= vl_s4;
			nl_s5    <= nl_s4;
			nr_s5    <= nr_s4;
			dp_s5    <= dp_s4;
		end
	end

	// ---------------- attenuation divide ----------------
	logic               vld_qa;
	logic [0:0][G:0]    q_qa;
	logic [SIDEA_W-1:0] side_qa;

	svgp_frac_div_pipe #(
		.W      (DA_W),
		.QB     (G),
		.LANES  (1),
		.SIDE_W (SIDEA_W)
	) u_div_att (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s5),
		.num      (na_s5),
		.den      (da_s5),
		.side_in  ({vl_s5, sp_s5, lemin_s5, gemax_s5, nl_s5, nr_s5, dp_s5}),
		.out_valid(vld_qa),
		.quot     (q_qa),
		.side_out (side_qa)
	);

	// ---------------- stage 6: attenuation select, total gain ----------------
	logic [VL_W-1:0] vl_a;
	logic            sp_a, lemin_a, gemax_a;
	logic [DP_W-1:0] nl_a, nr_a, dp_a;
	logic [G:0]      att_c;

	always_comb begin
		{vl_a, sp_a, lemin_a, gemax_a, nl_a, nr_a, dp_a} = side_qa;
		// unity when not spatial or within min distance, zero at or beyond max, else the fade
		if (!sp_a || lemin_a) begin
			att_c = GAIN_ONE;
		end else if (gemax_a) begin
			att_c = '0;
		end else begin
			att_c = q_qa[0];
		end
	end

	logic            vld_s6;
	logic [T_W-1:0]  t_s6;
	logic            sp_s6;
	logic [DP_W-1:0] nl_s6, nr_s6, dp_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_qa;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			t_s6  <= T_W'(vl_a) * T_W'(att_c);
			sp_s6 <= sp_a;
			nl_s6 <= nl_a;
			nr_s6 <= nr_a;
			dp_s6 <= dp_a;
		end
	end

	// ---------------- stage 7: silence test, gain ----------------
	logic             vld_s7;
	logic [GV_W-1:0]  g_s7;
	logic             sil_s7, sp_s7;
	logic [DP_W-1:0]  nl_s7, nr_s7, dp_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			g_s7   <= t_s6[T_W-1:24];
			sil_s7 <= (t_s6 <= T_W'(SILENT_LIMIT));
			sp_s7  <= sp_s6;
			nl_s7  <= nl_s6;
			nr_s7  <= nr_s6;
			dp_s7  <= dp_s6;
		end
	end

	// ---------------- pan power split: (r -/+ x) / 2r ----------------
	logic                 vld_qp;
	logic [1:0][2*G:0]    q_qp;
	logic [SIDEP_W-1:0]   side_qp;

	svgp_frac_div_pipe #(
		.W      (DP_W),
		.QB     (2 * G),
		.LANES  (2),
		.SIDE_W (SIDEP_W)
	) u_div_pan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_s7),
		.num      ({nr_s7, nl_s7}),
		.den      ({dp_s7, dp_s7}),
		.side_in  ({g_s7, sil_s7, sp_s7}),
		.out_valid(vld_qp),
		.quot     (q_qp),
		.side_out (side_qp)
	);

	// ---------------- pan factors: square roots of the power split ----------------
	logic                 vld_f;
	logic [1:0][G:0]      f_f;
	logic [SIDEP_W-1:0]   side_f;

	svgp_isqrt_pipe #(
		.IN_W   (2 * G + 2),
		.LANES  (2),
		.SIDE_W (SIDEP_W)
	) u_root_pan (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_qp),
		.rad      ({{1'b0, q_qp[1]}, {1'b0, q_qp[0]}}),
		.side_in  (side_qp),
		.out_valid(vld_f),
		.root     (f_f),
		.side_out (side_f)
	);

	// ---------------- stage 8: gain times pan factor ----------------
	logic [GV_W-1:0] g_f;
	logic            sil_f, sp_f;

	always_comb begin
		{g_f, sil_f, sp_f} = side_f;
	end

	logic              vld_s8;
	logic [PROD_W-1:0] pl_s8, pr_s8;
	logic [GV_W-1:0]   g_s8;
	logic              sil_s8, sp_s8;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s8 <= 1'b0;
		end else if (en) begin
			vld_s8 <= vld_f;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pl_s8  <= PROD_W'(g_f) * PROD_W'(f_f[0]);
			pr_s8  <= PROD_W'(g_f) * PROD_W'(f_f[1]);
			g_s8   <= g_f;
			sil_s8 <= sil_f;
			sp_s8  <= sp_f;
		end
	end

	// ---------------- stage 9: saturate, output register ----------------
	function automatic logic [23:0] sat_gain(input logic [SAT_W-1:0] v);
		return (v > SAT_W'(svgp_pkg::GAIN_MAX)) ? svgp_pkg::GAIN_MAX : v[23:0];
	endfunction

	logic [23:0] left_c, right_c;

	always_comb begin
		if (sil_s8) begin
			left_c  = '0;
			right_c = '0;
		end else if (!sp_s8) begin
			left_c  = sat_gain(SAT_W'(g_s8));
			right_c = left_c;
		end else begin
			left_c  = sat_gain(SAT_W'(pl_s8[PROD_W-1:G]));
			right_c = sat_gain(SAT_W'(pr_s8[PROD_W-1:G]));
		end
	end

	logic        vld_s9;
	logic [23:0] left_s9, right_s9;
	logic        sil_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s9 <= 1'b0;
		end else if (en) begin
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			left_s9  <= left_c;
			right_s9 <= right_c;
			sil_s9   <= sil_s8;
		end
	end

	assign out_valid  = vld_s9;
	assign left_gain  = left_s9;
	assign right_gain = right_s9;
	assign silent     = sil_s9;

endmodule
`default_nettype wire

### tb/spatial_voice_gain_pan_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spatial_voice_gain_pan_test
// Self-checking bench: voices are predicted in fixed point and compared with
// the block's left and right gains and silent flag, over several listener
// gain settings, random idle gaps and one long output hold-off.
// ----------------------------------------------------------------------------
module spatial_voice_gain_pan_test;

	localparam int GF = 16;
	localparam longint unsigned MIN_FLOOR = ((64'd5 << 8) + 64'd50) / 64'd100;
	localparam longint unsigned GAIN_ONE = 64'd1 << GF;
	localparam longint unsigned SILENT_LIMIT = (64'd1 << (24 + GF)) / 64'd100000;
	localparam int DRAIN_CYCLES = 300;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic [23:0] x, y, z;
		logic [15:0] vol;
		logic [23:0] mn, mx;
		logic        sp;
	} voice_t;

	typedef struct packed {
		logic [23:0] left, right;
		logic        mute;
	} gains_t;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0, out_stall = 0, cfg_valid = 0;
	logic in_stall, out_valid, cfg_ready, silent;
	logic [23:0] ox = 0, oy = 0, oz = 0, mnd = 0, mxd = 0;
	logic [15:0] vol = 0, cfg_data = 0;
	logic sp = 0;
	logic [23:0] left_gain, right_gain;

	voice_t pending_voices[$];
	gains_t expected_gains[$];
	longint unsigned listener_gain = svgp_pkg::LISTENER_GAIN_RESET;
	int mismatches = 0, idle_cycles = 0;
	int hold_off = 0;
	bit timed_out = 0;
	bit in_taken = 0;

	always #5 clk = ~clk;

	spatial_voice_gain_pan dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.offset_x(ox), .offset_y(oy), .offset_z(oz),
		.volume(vol), .min_distance(mnd), .max_distance(mxd), .spatial(sp),
		.out_valid(out_valid), .out_stall(out_stall),
		.left_gain(left_gain), .right_gain(right_gain), .silent(silent),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	function automatic longint unsigned int_sqrt(longint unsigned v);
		longint unsigned root, b;
		root = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= root + b) begin
				v -= root + b;
				root = (root >> 1) + b;
			end else
				root >>= 1;
			b >>= 2;
		end
		return root;
	endfunction

	// floor(n * 2^bits / d), n <= d
	function automatic longint unsigned ratio_bits(longint unsigned n, longint unsigned d,
			int bits);
		longint unsigned ip, q;
		ip = 0;
		q = 0;
		if (d == 0) return 0;
		if (n >= d) begin
			ip = 1;
			n -= d;
		end
		for (int i = 0; i < bits; i++) begin
			n <<= 1;
			q <<= 1;
			if (n >= d) begin
				q |= 1;
				n -= d;
			end
		end
		return (ip << bits) | q;
	endfunction

	function automatic longint unsigned magnitude(logic [23:0] v);
		return v[23] ? 64'h1000000 - v : v;
	endfunction

	function automatic longint unsigned clip24(longint unsigned v);
		return v > svgp_pkg::GAIN_MAX ? svgp_pkg::GAIN_MAX : v;
	endfunction

	function automatic gains_t voice_gains(voice_t v);
		gains_t res;
		longint unsigned ax, ay, az, cv, vl, att, tot, g, mn, mx, d;
		longint unsigned r2, r, xs, nl, nr, den, fl, fr;
		ax = magnitude(v.x);
		ay = magnitude(v.y);
		az = magnitude(v.z);
		cv = v.vol > svgp_pkg::VOLUME_CAP ? svgp_pkg::VOLUME_CAP : v.vol;
		vl = cv * listener_gain;
		att = GAIN_ONE;
		if (v.sp) begin
			d = int_sqrt(ax * ax + ay * ay + az * az);
			mn = v.mn < MIN_FLOOR ? MIN_FLOOR : v.mn;
			mx = v.mx < mn + MIN_FLOOR ? mn + MIN_FLOOR : v.mx;
			if (d <= mn) att = GAIN_ONE;
			else if (d >= mx) att = 0;
			else att = ratio_bits(mn * (mx - d), d * (mx - mn), GF);
		end
		tot = vl * att;
		if (tot <= SILENT_LIMIT) begin
			res.left = 0;
			res.right = 0;
			res.mute = 1;
			return res;
		end
		g = tot >> 24;
		res.mute = 0;
		if (v.sp) begin
			r2 = ax * ax + az * az;
			if (r2 == 0) begin
				nl = 1;
				nr = 1;
				den = 2;
			end else begin
				r = int_sqrt(r2 << 16);
				xs = ax << 8;
				if (xs > r) xs = r;
				nl = v.x[23] ? r + xs : r - xs;
				nr = v.x[23] ? r - xs : r + xs;
				den = 2 * r;
			end
			fl = int_sqrt(ratio_bits(nl, den, 2 * GF));
			fr = int_sqrt(ratio_bits(nr, den, 2 * GF));
			res.left = clip24((g * fl) >> GF);
			res.right = clip24((g * fr) >> GF);
		end else begin
			res.left = clip24(g);
			res.right = res.left;
		end
		return res;
	endfunction

	// no gap more often than not, else mostly short gaps and a few long ones
	function automatic int gap_len();
		int p;
		p = $urandom_range(99);
		if (p < 55) return 0;
		if (p < 93) return $urandom_range(3, 1);
		return $urandom_range(40, 8);
	endfunction

	function automatic logic [23:0] rand_pos();
		case ($urandom_range(4))
			0: return 24'($urandom);
			1: return 24'($urandom_range(8191) - 4096);
			2: return 24'(int'($urandom_range(4095)) - 2048);
			default: return 24'($urandom_range(131071) - 65536);
		endcase
	endfunction

	function automatic voice_t rand_voice();
		voice_t v;
		v.x = rand_pos();
		v.y = $urandom_range(3) == 0 ? 24'd0 : rand_pos();
		v.z = rand_pos();
		v.vol = $urandom_range(3) == 0 ? 16'($urandom) : 16'($urandom_range(20000));
		case ($urandom_range(3))
			0: begin
				v.mn = 24'($urandom);
				v.mx = 24'($urandom);
			end
			1: begin
				v.mn = 24'($urandom_range(20));
				v.mx = 24'($urandom_range(30));
			end
			default: begin
				v.mn = 24'($urandom_range(4000));
				v.mx = v.mn + 24'($urandom_range(60000));
			end
		endcase
		v.sp = $urandom_range(4) != 0;
		return v;
	endfunction

	function automatic voice_t make_voice(logic [23:0] x, y, z, logic [15:0] vl,
			logic [23:0] mn, mx, logic s);
		voice_t v;
		v = '{x, y, z, vl, mn, mx, s};
		return v;
	endfunction

	task automatic add_voice(voice_t v);
		pending_voices = {pending_voices, v};
	endtask

	// input acceptance seen at the rising edge, prediction queued in order
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			expected_gains = {expected_gains, voice_gains(pending_voices.pop_front())};
			in_taken <= 1'b1;
		end else
			in_taken <= 1'b0;
	end

	// driver: holds a request until accepted, gaps between requests
	int send_gap = 0;
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_taken)
				send_gap = gap_len();
			if (in_taken || !in_valid) begin
				if (send_gap > 0) begin
					send_gap--;
					in_valid <= 0;
				end else if (pending_voices.size() > 0) begin
					{ox, oy, oz, vol, mnd, mxd, sp} <= pending_voices[0];
					in_valid <= 1;
				end else
					in_valid <= 0;
			end
		end
	end

	// receiver stall pattern, with an optional long hold-off
	int stall_left = 0;
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off--;
			out_stall <= 1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1;
		end else begin
			stall_left = $urandom_range(3) == 0 ? gap_len() : 0;
			out_stall <= stall_left > 0;
		end
	end

	// monitor: compare each accepted result with the oldest prediction
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (expected_gains.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h %h %b",
					left_gain, right_gain, silent);
			end else begin
				gains_t e;
				e = expected_gains.pop_front();
				if (e.left !== left_gain || e.right !== right_gain || e.mute !== silent) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch exp %h %h %b got %h %h %b", e.left, e.right,
							e.mute, left_gain, right_gain, silent);
				end
			end
		end
	end

	// watchdog on cycles with no request accepted on either side, outside the hold-off
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || hold_off > 0)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
	end

	task automatic write_listener_gain(logic [15:0] value);
		@(negedge clk);
		cfg_data <= value;
		cfg_valid <= 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		listener_gain = value;
		@(negedge clk);
		cfg_valid <= 0;
	endtask

	task automatic drain();
		while ((pending_voices.size() > 0 || expected_gains.size() > 0 || in_valid)
				&& !timed_out) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic queue_random(int count);
		repeat (count) add_voice(rand_voice());
	endtask

	initial begin
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: extremes, special cases, default gain
		add_voice(make_voice(0, 0, 0, 16'd4096, 0, 0, 1));   // at listener
		add_voice(make_voice(0, 24'd5000, 0, 16'd4096, 24'd100, 24'd90000, 1));
		add_voice(make_voice(24'h7FFFFF, 0, 0, 16'hFFFF, 24'hFFFFFF,
			24'hFFFFFF, 1));
		add_voice(make_voice(24'h800000, 24'h800000, 24'h800000, 16'hFFFF,
			24'hFFFFFF, 24'hFFFFFF, 1));
		add_voice(make_voice(24'd512, 0, 24'hFFFF00, 16'd8192, 24'd256,
			24'd2560, 1));
		add_voice(make_voice(24'hFFFE00, 0, 0, 16'd4096, 24'd256, 24'd2560, 1));
		add_voice(make_voice(24'd1000, 0, 0, 16'd4096, 24'd100, 24'd200, 1));
		add_voice(make_voice(24'd3, 24'd2, 24'd1, 16'd4096, 0, 0, 1));
		add_voice(make_voice(24'd20, 0, 0, 16'd4096, 0, 0, 1));
		add_voice(make_voice(24'd500, 0, 0, 16'd4096, 24'd600, 24'd100, 1));
		add_voice(make_voice(24'h123456, 0, 0, 16'hFFFF, 0, 0, 0));
		add_voice(make_voice(0, 0, 0, 16'd0, 0, 0, 0));
		add_voice(make_voice(0, 0, 0, 16'd1, 0, 0, 0));
		add_voice(make_voice(24'd5000, 24'd5000, 24'd5000, 16'd1, 24'd10,
			24'd90000, 1));
		add_voice(make_voice(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 16'h5555,
			24'hAAAAAA, 24'h555555, 1));
		drain();

		// largest listener gain and long receiver hold-off while the sender keeps offering
		write_listener_gain(16'hFFFF);
		add_voice(make_voice(0, 0, 0, 16'hFFFF, 0, 0, 0));
		add_voice(make_voice(0, 0, 0, 16'hFFFF, 0, 0, 1));
		hold_off = 400;
		queue_random(250);
		drain();

		write_listener_gain(16'd0);
		queue_random(100);
		drain();

		write_listener_gain(16'd1);
		queue_random(100);
		drain();

		write_listener_gain(svgp_pkg::LISTENER_GAIN_RESET);
		queue_random(300);
		drain();

		write_listener_gain(16'($urandom));
		queue_random(280);
		drain();

		if (timed_out || mismatches > 0 || expected_gains.size() > 0)
			$display("Regression FAIL");
		else
			$display("Regression PASS");
		$finish;
	end

	always @(posedge clk) begin
		if (timed_out) begin
			$display("Regression FAIL");
			$finish;
		end
	end

endmodule
